// ----- rtl/canopy_drag_tendency_unit_defines.svh -----
// Assertion macros for the RTL.
`ifndef CANOPY_DRAG_TENDENCY_UNIT_DEFINES_SVH
`define CANOPY_DRAG_TENDENCY_UNIT_DEFINES_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define CDT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define CDT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/cdt_pkg.sv -----
package cdt_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int DRAG_SHIFT = 3 * FRAC_BITS;

	localparam int DATA_W    = 32;
	localparam int CD_W      = 21;
	localparam int DENS_W    = 25;
	localparam int CFG_IDX_W = 2;
	localparam int SUM_W     = DATA_W + 2;
	localparam int SQ_W      = 2 * DATA_W;
	localparam int ROOT_W    = DATA_W;
	localparam int REM_W     = SQ_W + 2;
	localparam int SQ_STAGES = ROOT_W;
	localparam int PROD_W    = CD_W + DENS_W;
	localparam int HALF_W    = PROD_W / 2;
	localparam int HI_W      = PROD_W - HALF_W;
	localparam int PP_W      = HI_W + DATA_W;
	localparam int LO_W      = PP_W + DATA_W;
	localparam int WIDE_W    = PROD_W + SQ_W;
	localparam int Q_W       = WIDE_W - DRAG_SHIFT;
	localparam int DRAG_W    = DATA_W + 1;

	localparam logic [CD_W-1:0] CD_RESET = CD_W'(13107);

	typedef enum logic [1:0] {
		OP_U    = 2'd0,
		OP_V    = 2'd1,
		OP_W    = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DRAG_COEF = 2'd0,
		REG_TRANS_X   = 2'd1,
		REG_TRANS_Y   = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		op_t                       op;
		logic                      neg;
		logic [DATA_W-1:0]         mag;
		logic signed [DATA_W-1:0]  tend;
		logic [PROD_W-1:0]         dens;
	} side_t;

	function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [SUM_W-1:0] x);
		logic signed [DATA_W-1:0] r;
		if (x[SUM_W-1:DATA_W-1] == '0 || x[SUM_W-1:DATA_W-1] == '1)
			r = x[DATA_W-1:0];
		else if (x[SUM_W-1])
			r = {1'b1, {(DATA_W-1){1'b0}}};
		else
			r = {1'b0, {(DATA_W-1){1'b1}}};
		return r;
	endfunction

endpackage

// ----- rtl/cdt_if.sv -----
interface cdt_in_if;
	import cdt_pkg::*;

	logic                      valid;
	logic                      ready;
	logic [1:0]                op;
	logic signed [DATA_W-1:0]  own_velocity;
	logic signed [DATA_W-1:0]  other_a_0;
	logic signed [DATA_W-1:0]  other_a_1;
	logic signed [DATA_W-1:0]  other_a_2;
	logic signed [DATA_W-1:0]  other_a_3;
	logic signed [DATA_W-1:0]  other_b_0;
	logic signed [DATA_W-1:0]  other_b_1;
	logic signed [DATA_W-1:0]  other_b_2;
	logic signed [DATA_W-1:0]  other_b_3;
	logic [DENS_W-1:0]         area_density;
	logic signed [DATA_W-1:0]  tendency_in;

	modport source (
		output valid, op, own_velocity, other_a_0, other_a_1, other_a_2, other_a_3,
		output other_b_0, other_b_1, other_b_2, other_b_3, area_density, tendency_in,
		input  ready
	);
	modport sink (
		input  valid, op, own_velocity, other_a_0, other_a_1, other_a_2, other_a_3,
		input  other_b_0, other_b_1, other_b_2, other_b_3, area_density, tendency_in,
		output ready
	);
endinterface

interface cdt_out_if;
	import cdt_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [DATA_W-1:0]  tendency_out;

	modport source (output valid, tendency_out, input ready);
	modport sink (input valid, tendency_out, output ready);
endinterface

// ----- rtl/cdt_isqrt.sv -----
module cdt_isqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [cdt_pkg::SQ_W-1:0]    x,
	input  cdt_pkg::side_t              side_in,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [cdt_pkg::ROOT_W-1:0]  root,
	output cdt_pkg::side_t              side_out
);
	import cdt_pkg::*;

	// one result bit per stage, MSB first; remainder kept as x - root^2
	logic [SQ_STAGES:1] v_s;
	logic [SQ_STAGES:1] en;
	logic [REM_W-1:0]   rem_s  [1:SQ_STAGES];
	logic [ROOT_W-1:0]  root_s [1:SQ_STAGES];
	side_t              side_s [1:SQ_STAGES];

	genvar k;
	for (k = 1; k <= SQ_STAGES; k++) begin : g_stage
		localparam int BIT = ROOT_W - k;

		logic              v_prev;
		logic [REM_W-1:0]  rem_prev;
		logic [ROOT_W-1:0] root_prev;
		side_t             side_prev;
		logic [REM_W-1:0]  trial;
		logic              take;

		if (k == 1) begin : g_first
			assign v_prev    = in_valid;
			assign rem_prev  = REM_W'(x);
			assign root_prev = '0;
			assign side_prev = side_in;
		end else begin : g_next
			assign v_prev    = v_s[k-1];
			assign rem_prev  = rem_s[k-1];
			assign root_prev = root_s[k-1];
			assign side_prev = side_s[k-1];
		end

		if (k == SQ_STAGES) begin : g_last_en
			assign en[k] = !v_s[k] || out_ready;
		end else begin : g_mid_en
			assign en[k] = !v_s[k] || en[k+1];
		end

		assign trial = (REM_W'(root_prev) << (BIT + 1)) | (REM_W'(1) << (2 * BIT));
		assign take  = rem_prev >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_s[k] <= 1'b0;
			else if (en[k])
				v_s[k] <= v_prev;
		end

		always_ff @(posedge clk) begin
			if (en[k]) begin
				rem_s[k]  <= take ? rem_prev - trial : rem_prev;
				root_s[k] <= take ? (root_prev | (ROOT_W'(1) << BIT)) : root_prev;
				side_s[k] <= side_prev;
			end
		end
	end

	assign in_ready  = en[1];
	assign out_valid = v_s[SQ_STAGES];
	assign root      = root_s[SQ_STAGES];
	assign side_out  = side_s[SQ_STAGES];

endmodule

// ----- rtl/canopy_drag_tendency_unit.sv -----
// Stages: 4 front, 32 square-root at one root bit each, 5 multiply and saturate.
// Throughput: one item per cycle while result.ready stays high; each stage advances
// when it is empty or its successor advances, so bubbles close up under output
// backpressure.
// Reset (arst_n low): all stage valids clear, drag_coefficient returns to 13107,
// translation velocities to zero.
`include "canopy_drag_tendency_unit_defines.svh"

module canopy_drag_tendency_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [cdt_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [cdt_pkg::DATA_W-1:0]      cfg_data,
	cdt_in_if.sink                          item,
	cdt_out_if.source                       result
);
	import cdt_pkg::*;

	// configuration
	logic [CD_W-1:0]          cd_q;
	logic signed [DATA_W-1:0] tvx_q;
	logic signed [DATA_W-1:0] tvy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cd_q  <= CD_RESET;
			tvx_q <= '0;
			tvy_q <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_DRAG_COEF: cd_q  <= cfg_data[CD_W-1:0];
				REG_TRANS_X:   tvx_q <= $signed(cfg_data);
				REG_TRANS_Y:   tvy_q <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	// stage valids and advance enables
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6, en_s7, en_s8, en_s9;
	logic sq_in_ready;
	logic sq_valid;

	assign en_s9 = !v_s9 || result.ready;
	assign en_s8 = !v_s8 || en_s9;
	assign en_s7 = !v_s7 || en_s8;
	assign en_s6 = !v_s6 || en_s7;
	assign en_s5 = !v_s5 || en_s6;
	assign en_s4 = !v_s4 || sq_in_ready;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;

	assign item.ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= item.valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= sq_valid;
			if (en_s6) v_s6 <= v_s5;
			if (en_s7) v_s7 <= v_s6;
			if (en_s8) v_s8 <= v_s7;
			if (en_s9) v_s9 <= v_s8;
		end
	end

	// s1: neighbour averages (floor by arithmetic shift), cd * density
	logic signed [SUM_W-1:0]  sum_a, sum_b;
	logic signed [DATA_W-1:0] avg_a_s1, avg_b_s1, own_s1, tend_s1;
	op_t                      op_s1;
	logic [PROD_W-1:0]        dens_s1;

	assign sum_a = SUM_W'(item.other_a_0) + SUM_W'(item.other_a_1)
	             + SUM_W'(item.other_a_2) + SUM_W'(item.other_a_3);
	assign sum_b = SUM_W'(item.other_b_0) + SUM_W'(item.other_b_1)
	             + SUM_W'(item.other_b_2) + SUM_W'(item.other_b_3);

	always_ff @(posedge clk) begin
		if (en_s1) begin
			avg_a_s1 <= sum_a[SUM_W-1:2];
			avg_b_s1 <= sum_b[SUM_W-1:2];
			own_s1   <= item.own_velocity;
			tend_s1  <= item.tendency_in;
			op_s1    <= op_t'(item.op);
			dens_s1  <= PROD_W'(cd_q) * PROD_W'(item.area_density);
		end
	end

	// s2: add translation velocities, saturate
	logic signed [DATA_W-1:0] add_own, add_a, add_b;
	logic signed [DATA_W-1:0] own_s2, a_s2, b_s2, tend_s2;
	op_t                      op_s2;
	logic [PROD_W-1:0]        dens_s2;

	always_comb begin
		case (op_s1)
			OP_U: begin
				add_own = tvx_q;
				add_a   = tvy_q;
				add_b   = '0;
			end
			OP_V: begin
				add_own = tvy_q;
				add_a   = tvx_q;
				add_b   = '0;
			end
			default: begin
				add_own = '0;
				add_a   = tvx_q;
				add_b   = tvy_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			own_s2  <= sat_data(SUM_W'(own_s1) + SUM_W'(add_own));
			a_s2    <= sat_data(SUM_W'(avg_a_s1) + SUM_W'(add_a));
			b_s2    <= sat_data(SUM_W'(avg_b_s1) + SUM_W'(add_b));
			tend_s2 <= tend_s1;
			op_s2   <= op_s1;
			dens_s2 <= dens_s1;
		end
	end

	// s3: squares and magnitude of own component
	logic signed [SQ_W-1:0] sq_own, sq_a, sq_b;
	logic [SQ_W-1:0]        sq_own_s3, sq_a_s3, sq_b_s3;
	side_t                  side_s3;

	assign sq_own = SQ_W'(own_s2) * SQ_W'(own_s2);
	assign sq_a   = SQ_W'(a_s2) * SQ_W'(a_s2);
	assign sq_b   = SQ_W'(b_s2) * SQ_W'(b_s2);

	always_ff @(posedge clk) begin
		if (en_s3) begin
			sq_own_s3    <= $unsigned(sq_own);
			sq_a_s3      <= $unsigned(sq_a);
			sq_b_s3      <= $unsigned(sq_b);
			side_s3.op   <= op_s2;
			side_s3.neg  <= own_s2[DATA_W-1];
			side_s3.mag  <= own_s2[DATA_W-1] ? $unsigned(-own_s2) : $unsigned(own_s2);
			side_s3.tend <= tend_s2;
			side_s3.dens <= dens_s2;
		end
	end

	// s4: sum of squares
	logic [SQ_W-1:0] sumsq_s4;
	side_t           side_s4;

	always_ff @(posedge clk) begin
		if (en_s4) begin
			sumsq_s4 <= sq_own_s3 + sq_a_s3 + sq_b_s3;
			side_s4  <= side_s3;
		end
	end

	// speed
	logic [ROOT_W-1:0] speed;
	side_t             side_sq;

	cdt_isqrt u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s4),
		.in_ready  (sq_in_ready),
		.x         (sumsq_s4),
		.side_in   (side_s4),
		.out_valid (sq_valid),
		.out_ready (en_s5),
		.root      (speed),
		.side_out  (side_sq)
	);

	// s5: speed * |own|
	logic [SQ_W-1:0] pm_s5;
	side_t           side_s5;

	always_ff @(posedge clk) begin
		if (en_s5) begin
			pm_s5   <= SQ_W'(speed) * SQ_W'(side_sq.mag);
			side_s5 <= side_sq;
		end
	end

	// s6: partial products of (cd * density) * (speed * |own|)
	logic [PP_W-1:0] pp_ll_s6, pp_lh_s6, pp_hl_s6, pp_hh_s6;
	side_t           side_s6;

	always_ff @(posedge clk) begin
		if (en_s6) begin
			pp_ll_s6 <= PP_W'(side_s5.dens[HALF_W-1:0]) * PP_W'(pm_s5[DATA_W-1:0]);
			pp_lh_s6 <= PP_W'(side_s5.dens[HALF_W-1:0]) * PP_W'(pm_s5[SQ_W-1:DATA_W]);
			pp_hl_s6 <= PP_W'(side_s5.dens[PROD_W-1:HALF_W]) * PP_W'(pm_s5[DATA_W-1:0]);
			pp_hh_s6 <= PP_W'(side_s5.dens[PROD_W-1:HALF_W]) * PP_W'(pm_s5[SQ_W-1:DATA_W]);
			side_s6  <= side_s5;
		end
	end

	// s7: combine halves
	logic [LO_W-1:0] lo_s7, hi_s7;
	side_t           side_s7;

	always_ff @(posedge clk) begin
		if (en_s7) begin
			lo_s7   <= LO_W'(pp_ll_s6) + (LO_W'(pp_lh_s6) << DATA_W);
			hi_s7   <= LO_W'(pp_hl_s6) + (LO_W'(pp_hh_s6) << DATA_W);
			side_s7 <= side_s6;
		end
	end

	// s8: full product, drop fraction bits
	logic [WIDE_W-1:0] total;
	logic [Q_W-1:0]    q_s8;
	side_t             side_s8;

	assign total = WIDE_W'(lo_s7) + (WIDE_W'(hi_s7) << HALF_W);

	always_ff @(posedge clk) begin
		if (en_s8) begin
			q_s8    <= Q_W'(total >> DRAG_SHIFT);
			side_s8 <= side_s7;
		end
	end

	// s9: clamp drag to 2^32, apply against sign of own, saturate; OP_NONE passes tend through
	logic                     over;
	logic [DRAG_W-1:0]        drag;
	logic signed [SUM_W-1:0]  acc;
	logic signed [DATA_W-1:0] res_s9;

	assign over = (|q_s8[Q_W-1:DRAG_W]) || (q_s8[DRAG_W-1] && (|q_s8[DRAG_W-2:0]));
	assign drag = over ? {1'b1, {(DRAG_W-1){1'b0}}} : q_s8[DRAG_W-1:0];
	assign acc  = side_s8.neg ? SUM_W'(side_s8.tend) + $signed(SUM_W'(drag))
	                          : SUM_W'(side_s8.tend) - $signed(SUM_W'(drag));

	always_ff @(posedge clk) begin
		if (en_s9)
			res_s9 <= (side_s8.op == OP_NONE) ? side_s8.tend : sat_data(acc);
	end

	assign result.valid        = v_s9;
	assign result.tendency_out = res_s9;

	`CDT_ASSERT_NOW(a_backpressure_full, !item.ready,
		v_s1 && v_s2 && v_s3 && v_s4 && !sq_in_ready && !result.ready,
		"input stalled while the pipeline has an empty stage")
	`CDT_ASSERT_NEXT(a_stall_keeps_s8, v_s8 && !en_s8, v_s8 && $stable(q_s8),
		"stalled item in stage 8 lost or changed")
	`CDT_ASSERT_NEXT(a_drag_sign_pos, en_s9 && v_s8 && side_s8.op != OP_NONE && !side_s8.neg,
		res_s9 <= $past(side_s8.tend), "drag raised tendency for positive component")
	`CDT_ASSERT_NEXT(a_drag_sign_neg, en_s9 && v_s8 && side_s8.op != OP_NONE && side_s8.neg,
		res_s9 >= $past(side_s8.tend), "drag lowered tendency for negative component")
	`CDT_ASSERT_NEXT(a_zero_drag_pass, en_s9 && v_s8 && q_s8 == '0,
		res_s9 == $past(side_s8.tend), "zero drag changed the tendency")

endmodule

// ----- tb/sv/canopy_drag_tendency_unit_test.sv -----
module canopy_drag_tendency_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	import cdt_pkg::*;

	localparam int CLK_PERIOD      = 4;
	localparam int RESET_CYCLES    = 8;
	localparam int ITEMS_PER_PHASE = 80;
	localparam int LONG_HOLD       = 400;
	localparam int TAIL_CYCLES     = 64;
	localparam int STALL_LIMIT     = 4000;
	localparam int REPORT_MAX      = 10;

	localparam logic signed [DATA_W-1:0] VMAX = 32'sh7FFF_FFFF;
	localparam logic signed [DATA_W-1:0] VMIN = 32'sh8000_0000;
	localparam logic signed [DATA_W-1:0] ONE  = 32'sh0001_0000;
	localparam logic [DENS_W-1:0]        DENS_MAX = 25'h100_0000;
	localparam logic [CD_W-1:0]          CD_MAX   = 21'h10_0000;

	typedef struct packed {
		op_t                      op;
		logic signed [DATA_W-1:0] own;
		logic [3:0][DATA_W-1:0]   other_a;
		logic [3:0][DATA_W-1:0]   other_b;
		logic [DENS_W-1:0]        dens;
		logic signed [DATA_W-1:0] tend;
	} point_t;

	class drag_scoreboard;
		logic [CD_W-1:0]          drag_coef;
		logic signed [DATA_W-1:0] trans_x;
		logic signed [DATA_W-1:0] trans_y;
		logic signed [DATA_W-1:0] expected_tendency_q[$];
		int                       errors;

		function new();
			drag_coef = CD_RESET;
			trans_x = '0;
			trans_y = '0;
			errors = 0;
		endfunction

		function void set_reg(cfg_reg_t idx, logic [DATA_W-1:0] data);
			case (idx)
				REG_DRAG_COEF: drag_coef = data[CD_W-1:0];
				REG_TRANS_X:   trans_x = data;
				REG_TRANS_Y:   trans_y = data;
				default: ;
			endcase
		endfunction

		function int pending();
			return expected_tendency_q.size();
		endfunction

		function longint clamp32(longint x);
			if (x > longint'(VMAX))
				return longint'(VMAX);
			if (x < longint'(VMIN))
				return longint'(VMIN);
			return x;
		endfunction

		function longint quarter_floor(logic [3:0][DATA_W-1:0] s);
			longint sum;
			sum = 0;
			for (int i = 0; i < 4; i++)
				sum += longint'($signed(s[i]));
			return sum >>> 2;
		endfunction

		function logic [31:0] root_floor(logic [63:0] x);
			logic [31:0] r;
			logic [31:0] t;
			r = '0;
			for (int i = 31; i >= 0; i--) begin
				t = r | (32'd1 << i);
				if (64'(t) * 64'(t) <= x)
					r = t;
			end
			return r;
		endfunction

		function logic signed [DATA_W-1:0] compute_tendency(point_t p);
			longint       own;
			longint       a;
			longint       b;
			longint       tend;
			longint       drag;
			longint       res;
			logic [63:0]  sumsq;
			logic [31:0]  spd;
			logic [31:0]  mag;
			logic [127:0] wide;
			logic [127:0] q;
			if (p.op == OP_NONE)
				return p.tend;
			own = longint'(p.own);
			a = quarter_floor(p.other_a);
			b = quarter_floor(p.other_b);
			tend = longint'(p.tend);
			case (p.op)
				OP_U: begin
					own = clamp32(own + longint'(trans_x));
					a = clamp32(a + longint'(trans_y));
					b = clamp32(b);
				end
				OP_V: begin
					own = clamp32(own + longint'(trans_y));
					a = clamp32(a + longint'(trans_x));
					b = clamp32(b);
				end
				default: begin
					own = clamp32(own);
					a = clamp32(a + longint'(trans_x));
					b = clamp32(b + longint'(trans_y));
				end
			endcase
			sumsq = own * own;
			sumsq += a * a;
			sumsq += b * b;
			spd = root_floor(sumsq);
			mag = (own < 0) ? 32'(-own) : 32'(own);
			wide = 128'(drag_coef) * 128'(p.dens) * 128'(spd) * 128'(mag);
			q = wide >> DRAG_SHIFT;
			drag = (q > 128'h1_0000_0000) ? 64'h1_0000_0000 : longint'(q[63:0]);
			res = (own < 0) ? tend + drag : tend - drag;
			return DATA_W'(clamp32(res));
		endfunction

		function void note_point(point_t p);
			expected_tendency_q.push_back(compute_tendency(p));
		endfunction

		function void check_tendency(logic signed [DATA_W-1:0] got);
			logic signed [DATA_W-1:0] want;
			if (expected_tendency_q.size() == 0) begin
				errors++;
				if (errors <= REPORT_MAX)
					$display("unexpected tendency_out %0d", got);
				return;
			end
			want = expected_tendency_q.pop_front();
			if (got !== want) begin
				errors++;
				if (errors <= REPORT_MAX)
					$display("tendency_out mismatch: expected %0d, got %0d", want, got);
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DATA_W-1:0]    cfg_data;
	int                   tx_idle_pct;
	int                   rx_stall_pct;
	int                   hold_requests;

	drag_scoreboard sb = new();

	cdt_in_if  item_ch();
	cdt_out_if result_ch();

	canopy_drag_tendency_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (item_ch),
		.result    (result_ch)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	always @(posedge clk) begin : monitor
		point_t seen;
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready)
				sb.check_tendency(result_ch.tendency_out);
			if (item_ch.valid && item_ch.ready) begin
				seen.op = op_t'(item_ch.op);
				seen.own = item_ch.own_velocity;
				seen.other_a[0] = item_ch.other_a_0;
				seen.other_a[1] = item_ch.other_a_1;
				seen.other_a[2] = item_ch.other_a_2;
				seen.other_a[3] = item_ch.other_a_3;
				seen.other_b[0] = item_ch.other_b_0;
				seen.other_b[1] = item_ch.other_b_1;
				seen.other_b[2] = item_ch.other_b_2;
				seen.other_b[3] = item_ch.other_b_3;
				seen.dens = item_ch.area_density;
				seen.tend = item_ch.tendency_in;
				sb.note_point(seen);
			end
		end
	end

	initial begin : receiver
		int hold_left;
		int hold_seen;
		hold_left = 0;
		hold_seen = 0;
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_requests != hold_seen) begin
				hold_seen = hold_requests;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
			end
		end
	end

	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (item_ch.valid && item_ch.ready) ||
			    (result_ch.valid && result_ch.ready))
				idle = 0;
			else
				idle++;
		end
		$display("timeout: no transfer for %0d cycles", STALL_LIMIT);
		$display("simulation failed");
		$finish;
	end

	function automatic logic signed [DATA_W-1:0] rand_vel();
		logic signed [DATA_W-1:0] v;
		v = $urandom;
		return v >>> $urandom_range(0, DATA_W - 1);
	endfunction

	function automatic point_t make_point(op_t op, logic signed [DATA_W-1:0] own,
			logic signed [DATA_W-1:0] a, logic signed [DATA_W-1:0] b,
			logic [DENS_W-1:0] dens, logic signed [DATA_W-1:0] tend);
		point_t p;
		p.op = op;
		p.own = own;
		for (int i = 0; i < 4; i++) begin
			p.other_a[i] = a;
			p.other_b[i] = b;
		end
		p.dens = dens;
		p.tend = tend;
		return p;
	endfunction

	task automatic send_point(point_t p);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(negedge clk);
		end
		item_ch.valid        <= 1'b1;
		item_ch.op           <= p.op;
		item_ch.own_velocity <= p.own;
		item_ch.other_a_0    <= p.other_a[0];
		item_ch.other_a_1    <= p.other_a[1];
		item_ch.other_a_2    <= p.other_a[2];
		item_ch.other_a_3    <= p.other_a[3];
		item_ch.other_b_0    <= p.other_b[0];
		item_ch.other_b_1    <= p.other_b[1];
		item_ch.other_b_2    <= p.other_b[2];
		item_ch.other_b_3    <= p.other_b[3];
		item_ch.area_density <= p.dens;
		item_ch.tendency_in  <= p.tend;
		do @(posedge clk); while (!item_ch.ready);
		@(negedge clk);
	endtask

	task automatic drain();
		item_ch.valid <= 1'b0;
		@(negedge clk);
		while (sb.pending() != 0)
			@(negedge clk);
	endtask

	task automatic write_config(logic [CD_W-1:0] cd, logic signed [DATA_W-1:0] tx,
			logic signed [DATA_W-1:0] ty);
		cfg_we    <= 1'b1;
		cfg_index <= REG_DRAG_COEF;
		cfg_data  <= DATA_W'(cd);
		sb.set_reg(REG_DRAG_COEF, DATA_W'(cd));
		@(negedge clk);
		cfg_index <= REG_TRANS_X;
		cfg_data  <= tx;
		sb.set_reg(REG_TRANS_X, tx);
		@(negedge clk);
		cfg_index <= REG_TRANS_Y;
		cfg_data  <= ty;
		sb.set_reg(REG_TRANS_Y, ty);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic run_phase(logic [CD_W-1:0] cd, logic signed [DATA_W-1:0] tx,
			logic signed [DATA_W-1:0] ty, int idle_pct, int stall_pct,
			bit long_hold, bit mid_drain);
		point_t p;
		int     r;
		drain();
		write_config(cd, tx, ty);
		tx_idle_pct = idle_pct;
		rx_stall_pct = stall_pct;
		if (long_hold)
			hold_requests++;
		for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
			r = $urandom_range(0, 15);
			p.op = (r == 0) ? OP_NONE : op_t'(r % 3);
			p.own = rand_vel();
			for (int k = 0; k < 4; k++) begin
				p.other_a[k] = rand_vel();
				p.other_b[k] = rand_vel();
			end
			r = $urandom_range(0, 19);
			p.dens = (r == 0) ? DENS_MAX :
				DENS_W'($urandom_range(0, DENS_MAX) >> $urandom_range(0, DENS_W - 1));
			p.tend = rand_vel();
			if (mid_drain && n == ITEMS_PER_PHASE / 2)
				drain();
			send_point(p);
		end
	endtask

	initial begin : main
		point_t p;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_DRAG_COEF;
		cfg_data = '0;
		item_ch.valid = 1'b0;
		item_ch.op = OP_U;
		item_ch.own_velocity = '0;
		item_ch.other_a_0 = '0;
		item_ch.other_a_1 = '0;
		item_ch.other_a_2 = '0;
		item_ch.other_a_3 = '0;
		item_ch.other_b_0 = '0;
		item_ch.other_b_1 = '0;
		item_ch.other_b_2 = '0;
		item_ch.other_b_3 = '0;
		item_ch.area_density = '0;
		item_ch.tendency_in = '0;
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		hold_requests = 0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed points under reset register values
		send_point(make_point(OP_U, '0, '0, '0, '0, '0));
		send_point(make_point(OP_V, '0, '0, '0, DENS_MAX, VMAX));
		send_point(make_point(OP_W, '0, VMAX, VMIN, DENS_MAX, VMIN));
		send_point(make_point(OP_NONE, VMAX, VMAX, VMAX, DENS_MAX, VMAX));
		send_point(make_point(OP_NONE, VMIN, VMIN, VMIN, '0, VMIN));
		send_point(make_point(OP_U, VMAX, VMAX, VMAX, DENS_MAX, VMAX));
		send_point(make_point(OP_V, VMIN, VMIN, VMIN, DENS_MAX, VMIN));
		send_point(make_point(OP_U, VMAX, VMIN, VMAX, DENS_MAX, VMIN));
		send_point(make_point(OP_W, VMIN, VMAX, VMIN, DENS_MAX, VMAX));
		send_point(make_point(OP_W, VMIN, VMAX, VMIN, '0, 32'sd12345));
		send_point(make_point(OP_U, ONE, ONE, '0, 25'(ONE), '0));
		send_point(make_point(OP_W, -ONE, '0, ONE, 25'(2 * ONE), -32'sd1000));
		p = make_point(OP_V, ONE, '0, '0, 25'(ONE), 32'sd77);
		p.other_a[0] = -32'sd1;
		p.other_b[2] = -32'sd5;
		send_point(p);
		p = make_point(OP_U, 3 * ONE, VMAX, VMIN, 25'(ONE), '0);
		p.other_a[2] = VMIN;
		p.other_a[3] = VMIN;
		p.other_b[0] = VMAX;
		send_point(p);
		send_point(make_point(OP_V, -3 * ONE, ONE / 2, -ONE / 4, 25'(ONE / 2), ONE));
		send_point(make_point(OP_W, 32'sd1, 32'sd1, 32'sd1, DENS_MAX, '0));

		run_phase(CD_RESET, '0, '0, 0, 0, 1'b0, 1'b0);
		run_phase('0, VMAX, VMIN, 45, 0, 1'b0, 1'b0);
		run_phase(CD_MAX, VMIN, VMAX, 0, 45, 1'b0, 1'b0);
		run_phase(CD_W'($urandom_range(0, CD_MAX)), rand_vel(), rand_vel(), 36, 36,
			1'b0, 1'b0);
		run_phase(CD_W'(1), rand_vel(), rand_vel(), 0, 0, 1'b1, 1'b0);
		run_phase(CD_W'(ONE), ONE, -ONE, 45, 0, 1'b0, 1'b1);
		run_phase(CD_W'($urandom_range(0, CD_MAX)), rand_vel(), rand_vel(), 0, 45,
			1'b0, 1'b0);
		run_phase(CD_W'($urandom_range(0, CD_MAX)), '0, '0, 36, 36, 1'b0, 1'b0);

		drain();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (sb.pending() != 0)
			$display("%0d tendency results never arrived", sb.pending());
		if (sb.errors == 0 && sb.pending() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/cdt_pkg.sv
rtl/cdt_if.sv
rtl/cdt_isqrt.sv
rtl/canopy_drag_tendency_unit.sv
tb/sv/canopy_drag_tendency_unit_test.sv
